// ===== hw/rtl/rmeu_pkg.sv =====
// Shared opcodes, fault codes and controller command/status types.
package rmeu_pkg;
	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_STORE = 4'd4;
	localparam logic [3:0] OP_LOAD = 4'd5;
	localparam logic [3:0] OP_AFC  = 4'd6;
	localparam logic [3:0] OP_EQU  = 4'd7;
	localparam logic [3:0] OP_INF  = 4'd8;
	localparam logic [3:0] OP_INFE = 4'd9;
	localparam logic [3:0] OP_SUP  = 4'd10;
	localparam logic [3:0] OP_SUPE = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_JMPC = 4'd13;
	localparam logic [3:0] OP_CALL = 4'd14;
	localparam logic [3:0] OP_RET  = 4'd15;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_INDEX = 2'd1;
	localparam logic [1:0] FLT_OVER  = 2'd2;
	localparam logic [1:0] FLT_UNDER = 2'd3;

	localparam int PC_W = 10;
	localparam int DIV_STEPS = 32;

	typedef struct packed {
		logic latch;    // capture instruction
		logic rd_regs;  // register operands, memory word and return address to be read
		logic div_init; // start the divider
		logic div_step; // one quotient bit
		logic commit;   // write state and present result
	} ctl_cmd_t;

	typedef struct packed {
		logic is_div;
		logic div_last;
		logic hold;     // result strobe or memory clearing in progress
	} dp_sts_t;
endpackage

// ===== hw/rtl/rmeu_ctrl.sv =====
// Controller sequencing one instruction through read, divide and commit.
module rmeu_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rmeu_pkg::dp_sts_t sts,
	output rmeu_pkg::ctl_cmd_t cmd
);
	import rmeu_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && !sts.hold) begin
					cmd.latch = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_regs = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.is_div) begin
					cmd.div_init = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_DONE;
			end
			S_DONE: begin
				cmd.commit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// stay busy through the result cycle so the strobe never overlaps a new transfer
	assign busy = (state_q != S_IDLE) || sts.hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> $past(state_q == S_EXEC || state_q == S_DIV))
		else $error("divide state entered out of sequence");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit)
		else $error("commit repeated");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer not taken");
endmodule

// ===== hw/rtl/rmeu_dpath.sv =====
// Datapath: register file, data memory, return stack, ALU and serial divider.
module rmeu_dpath #(
	parameter int DATA_WORDS = 1024,
	parameter int STACK_ENTRIES = 8,
	parameter int REG_COUNT = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [3:0] op,
	input  logic [9:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  rmeu_pkg::ctl_cmd_t cmd,
	output rmeu_pkg::dp_sts_t sts,
	output logic done,
	output logic [9:0] next_index,
	output logic reg_written,
	output logic signed [31:0] written_value,
	output logic [1:0] fault
);
	import rmeu_pkg::*;

	localparam int MA_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam int SA_W = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
	localparam int SD_W = $clog2(STACK_ENTRIES + 1);
	localparam int RI_W = $clog2(REG_COUNT);

	logic [31:0] rf_q [REG_COUNT];
	logic [31:0] mem [DATA_WORDS];
	logic [PC_W-1:0] stk [STACK_ENTRIES];
	logic [SD_W-1:0] sdep_q;
	logic [PC_W-1:0] pc_q;

	// memory clearing pass after reset, one word per cycle
	logic [MA_W-1:0] clr_q;
	logic clr_act_q;

	logic [3:0] op_q;
	logic [9:0] a_q;
	logic [31:0] b_q;
	logic [31:0] x_q, y_q, mw_q;
	logic [PC_W-1:0] ret_q;
	logic [31:0] prod_q;

	// serial divider
	logic [31:0] rem_q, quo_q, dvs_q;
	logic neg_q, dz_q;
	logic [5:0] cnt_q;

	logic a_ok, b_ok, sa_ok, lb_ok;
	assign a_ok = {22'd0, a_q} < 32'(REG_COUNT);
	assign b_ok = b_q < 32'(REG_COUNT);
	assign sa_ok = {22'd0, a_q} < 32'(DATA_WORDS);
	assign lb_ok = b_q < 32'(DATA_WORDS);

	assign sts.is_div = (op_q == OP_DIV) && a_ok && b_ok;
	assign sts.div_last = (cnt_q == 6'(DIV_STEPS - 1));
	assign sts.hold = done | clr_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b1;
			clr_q <= '0;
		end else if (clr_act_q) begin
			clr_q <= clr_q + MA_W'(1);
			if (clr_q == MA_W'(DATA_WORDS - 1)) clr_act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= op;
			a_q <= operand_a;
			b_q <= operand_b;
		end
		if (cmd.rd_regs) begin
			x_q <= rf_q[a_q[RI_W-1:0]];
			y_q <= rf_q[b_q[RI_W-1:0]];
			mw_q <= mem[b_q[MA_W-1:0]];
			ret_q <= stk[SA_W'(sdep_q - SD_W'(1))];
		end
		prod_q <= x_q * y_q;
		if (clr_act_q)
			mem[clr_q] <= '0;
		else if (cmd.commit && op_q == OP_STORE && b_ok && sa_ok)
			mem[MA_W'(a_q)] <= y_q;
		if (cmd.commit && op_q == OP_CALL && sdep_q < SD_W'(STACK_ENTRIES))
			stk[sdep_q[SA_W-1:0]] <= b_q[PC_W-1:0];
	end

	logic [32:0] trial;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= x_q[31] ? -x_q : x_q;
			dvs_q <= y_q[31] ? -y_q : y_q;
			neg_q <= x_q[31] ^ y_q[31];
			dz_q <= (y_q == 32'd0);
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 6'd1;
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	function automatic logic [31:0] truth(input logic c);
		truth = c ? 32'd1 : 32'hFFFF_FFFF;
	endfunction

	logic [31:0] val;
	logic [1:0] flt;
	logic wreg;
	logic [PC_W-1:0] nxt;
	logic push, pop;
	logic signed [31:0] sx, sy;
	assign sx = x_q;
	assign sy = y_q;

	always_comb begin
		val = '0; flt = FLT_NONE; wreg = 1'b0; push = 1'b0; pop = 1'b0;
		nxt = pc_q + PC_W'(1);
		case (op_q)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQU, OP_INF, OP_INFE, OP_SUP, OP_SUPE: begin
				if (!a_ok || !b_ok) flt = FLT_INDEX;
				else begin
					wreg = 1'b1;
					case (op_q)
						OP_ADD: val = x_q + y_q;
						OP_SUB: val = x_q - y_q;
						OP_MUL: val = prod_q;
						OP_DIV: val = dz_q ? 32'd0 : (neg_q ? -quo_q : quo_q);
						OP_EQU: val = truth(x_q == y_q);
						OP_INF: val = truth(sx < sy);
						OP_INFE: val = truth(sx <= sy);
						OP_SUP: val = truth(sx > sy);
						default: val = truth(sx >= sy);
					endcase
				end
			end
			OP_STORE: begin
				if (!b_ok || !sa_ok) flt = FLT_INDEX;
				else val = y_q;
			end
			OP_LOAD: begin
				if (!a_ok || !lb_ok) flt = FLT_INDEX;
				else begin
					val = mw_q;
					wreg = 1'b1;
				end
			end
			OP_AFC: begin
				if (!a_ok) flt = FLT_INDEX;
				else begin
					val = b_q;
					wreg = 1'b1;
				end
			end
			OP_JMP: nxt = a_q + PC_W'(1);
			OP_JMPC: begin
				if (!b_ok) flt = FLT_INDEX;
				else if (y_q == 32'hFFFF_FFFF) nxt = a_q + PC_W'(1);
			end
			OP_CALL: begin
				if (sdep_q >= SD_W'(STACK_ENTRIES)) flt = FLT_OVER;
				else begin
					push = 1'b1;
					nxt = a_q + PC_W'(1);
				end
			end
			default: begin
				if (sdep_q == '0) flt = FLT_UNDER;
				else begin
					pop = 1'b1;
					nxt = ret_q + PC_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
			sdep_q <= '0;
			pc_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.commit) begin
				if (wreg) rf_q[a_q[RI_W-1:0]] <= val;
				if (push) sdep_q <= sdep_q + SD_W'(1);
				if (pop) sdep_q <= sdep_q - SD_W'(1);
				pc_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_index <= nxt;
			reg_written <= wreg;
			written_value <= val;
			fault <= flt;
		end
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sdep_q <= SD_W'(STACK_ENTRIES))
		else $error("stack depth beyond capacity");
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fault != FLT_NONE) |-> (!reg_written && written_value == 32'd0))
		else $error("faulted instruction wrote a value");
	a_pc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pc_q == next_index))
		else $error("program counter out of step with result");
endmodule

// ===== hw/rtl/register_machine_execute_unit.sv =====
// Register machine execute unit: top level joining controller and datapath.
// Each instruction is latched, its operands read, then executed (DIV through the bit-serial divider) and committed;
// the result is registered, and a new instruction is taken only after the result strobe.
// busy stays high from the start transfer through the result strobe; the receiver cannot stall.
// Asynchronous reset clears registers, stack depth and PC, then busy holds while every data memory word is cleared.
module register_machine_execute_unit #(
	parameter int DATA_WORDS = 1024,
	parameter int STACK_ENTRIES = 8,
	parameter int REG_COUNT = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [3:0] op,
	input  logic [9:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic done,
	output logic [9:0] next_index,
	output logic reg_written,
	output logic signed [31:0] written_value,
	output logic [1:0] fault
);
	import rmeu_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t sts;

	rmeu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	rmeu_dpath #(
		.DATA_WORDS(DATA_WORDS), .STACK_ENTRIES(STACK_ENTRIES), .REG_COUNT(REG_COUNT)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .op(op), .operand_a(operand_a), .operand_b(operand_b),
		.cmd(cmd), .sts(sts), .done(done), .next_index(next_index),
		.reg_written(reg_written), .written_value(written_value), .fault(fault)
	);
endmodule
